@@ rtl/mrcd_pkg.sv @@
// Shared types and constants for the multi-ratio clock divider.
// No dependencies; imported by mrcd_core and the top level.
`default_nettype none

package mrcd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 7;
    localparam int TIMER_W  = 32;
    localparam int ROM_GATES = 64;
    localparam int ROM_DEPTH = 128;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT   = 2'd2;

    // Reset values: 1.7 V at 10/32768 V per LSB, and all channels in use
    localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RESET = 16'sd5571;
    localparam logic [COUNT_W-1:0]         CHANNELS_RESET  = 7'd64;

    // One input beat
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] clock_sample;
        logic signed [SAMPLE_W-1:0] reset_sample;
        logic                       clock_connected;
    } t_tick;

    // Divisibility table: bit i of entry s is set when s is a multiple of i+1
    typedef logic [ROM_DEPTH-1:0][ROM_GATES-1:0] t_div_rom;

    function automatic t_div_rom build_div_rom();
        t_div_rom rom;
        rom = '0;
        for (int i = 0; i < ROM_GATES; i++) begin
            for (int m = 0; m < ROM_DEPTH; m = m + i + 1) begin
                rom[m][i] = 1'b1;
            end
        end
        return rom;
    endfunction

    localparam t_div_rom DIV_ROM = build_div_rom();

endpackage

`default_nettype wire

@@ rtl/mrcd_core.sv @@
// Divider core: config registers, edge detection, interval timing and gates.
// Depends on mrcd_pkg for the tick type, register indexes and divisibility table.
`default_nettype none

module mrcd_core
    import mrcd_pkg::*;
#(
    parameter int MAX_CHANNELS = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  wire t_tick                       i_tick,
    input  wire logic                        i_advance,
    output logic                             o_push,
    output logic [MAX_CHANNELS-1:0]          o_gate_mask,
    output logic signed [SAMPLE_W-1:0]       o_gated_sample
);

    localparam logic [COUNT_W-1:0] MAX_C = COUNT_W'(MAX_CHANNELS);
    localparam logic [TIMER_W-1:0] SAT   = '1;

    // Config registers
    logic signed [SAMPLE_W-1:0] r_clk_thr, r_rst_thr;
    logic [COUNT_W-1:0]         r_chan_cnt;

    // Divider state
    logic                    r_clk_prev, r_rst_prev, r_armed;
    logic [TIMER_W-1:0]      r_gap, r_meas, r_since;
    logic [COUNT_W-1:0]      r_step;
    logic [MAX_CHANNELS-1:0] r_gates;

    logic                    n_clk_prev, n_rst_prev, n_armed;
    logic [TIMER_W-1:0]      n_gap, n_meas, n_since;
    logic [COUNT_W-1:0]      n_step;
    logic [MAX_CHANNELS-1:0] n_gates;

    // State after an optional reset-edge clear
    logic                    b_clk_prev, b_armed;
    logic [TIMER_W-1:0]      b_gap, b_meas, b_since;
    logic [COUNT_W-1:0]      b_step;
    logic [MAX_CHANNELS-1:0] b_gates;

    logic                    rst_level, rst_edge, clk_level, clk_edge;
    logic [TIMER_W-1:0]      gap_inc, since_inc;
    logic [COUNT_W-1:0]      used, step_inc;
    logic [MAX_CHANNELS-1:0] used_mask, fresh;
    logic                    commit;

    assign commit = i_advance & i_tick.clock_connected;

    // Channels in use, clipped to the gate count
    assign used = (r_chan_cnt < MAX_C) ? r_chan_cnt : MAX_C;
    always_comb begin
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            used_mask[i] = (COUNT_W'(i) < used);
        end
    end

    // Next-state logic for one tick
    always_comb begin
        rst_level  = (i_tick.reset_sample >= r_rst_thr);
        rst_edge   = rst_level & ~r_rst_prev;
        n_rst_prev = rst_level;

        if (rst_edge) begin
            b_clk_prev = 1'b0;
            b_armed    = 1'b0;
            b_gap      = '0;
            b_meas     = '0;
            b_since    = '0;
            b_step     = '0;
            b_gates    = '0;
        end else begin
            b_clk_prev = r_clk_prev;
            b_armed    = r_armed;
            b_gap      = r_gap;
            b_meas     = r_meas;
            b_since    = r_since;
            b_step     = r_step;
            b_gates    = r_gates;
        end

        gap_inc    = (b_gap == SAT) ? b_gap : b_gap + 1'b1;
        clk_level  = (i_tick.clock_sample >= r_clk_thr);
        clk_edge   = clk_level & ~b_clk_prev;
        n_clk_prev = clk_level;
        n_meas     = clk_edge ? gap_inc : b_meas;
        n_gap      = clk_edge ? '0 : gap_inc;

        since_inc = (b_since == SAT) ? b_since : b_since + 1'b1;
        step_inc  = b_step + 1'b1;
        fresh     = DIV_ROM[step_inc][MAX_CHANNELS-1:0] & used_mask;

        n_armed = b_armed;
        n_since = b_since;
        n_step  = b_step;
        n_gates = b_gates;
        if (!b_armed) begin
            n_armed = clk_edge;
        end else begin
            n_since = since_inc;
            if (clk_edge) begin
                n_step  = step_inc;
                n_since = '0;
                n_gates = (b_gates & ~used_mask) | fresh;
            end else if (since_inc >= (n_meas >> 1)) begin
                n_gates = b_gates & ~used_mask;
            end
            if (n_step >= r_chan_cnt) begin
                n_step = '0;
            end
        end
    end

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_thr  <= THRESHOLD_RESET;
            r_rst_thr  <= THRESHOLD_RESET;
            r_chan_cnt <= CHANNELS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CLOCK_THRESHOLD: r_clk_thr  <= i_cfg_data;
                REG_RESET_THRESHOLD: r_rst_thr  <= i_cfg_data;
                REG_CHANNEL_COUNT:   r_chan_cnt <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Divider state, updated once per connected tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_prev <= 1'b0;
            r_rst_prev <= 1'b0;
            r_armed    <= 1'b0;
            r_gap      <= '0;
            r_meas     <= '0;
            r_since    <= '0;
            r_step     <= '0;
            r_gates    <= '0;
        end else if (commit) begin
            r_clk_prev <= n_clk_prev;
            r_rst_prev <= n_rst_prev;
            r_armed    <= n_armed;
            r_gap      <= n_gap;
            r_meas     <= n_meas;
            r_since    <= n_since;
            r_step     <= n_step;
            r_gates    <= n_gates;
        end
    end

    // Result beat
    assign o_push         = commit;
    assign o_gate_mask    = n_gates;
    assign o_gated_sample = (|n_gates) ? i_tick.clock_sample : '0;

endmodule

`default_nettype wire

@@ rtl/mrcd_out_queue.sv @@
// Two-entry result queue that decouples the core from the output handshake.
// No package dependencies; instantiated by the top level.
`default_nettype none

module mrcd_out_queue #(
    parameter int WIDTH = 80
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_room,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [WIDTH-1:0]      o_data
);

    logic [WIDTH-1:0] r_q0, r_q1;
    logic [1:0]       r_cnt, n_cnt;
    logic             pop;
    logic [1:0]       slot;

    assign pop     = (r_cnt != 2'd0) & i_ready;
    assign o_room  = (r_cnt != 2'd2) | pop;
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q0;
    assign slot    = r_cnt - {1'b0, pop};
    assign n_cnt   = slot + {1'b0, i_push};

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Entries: shift on pop, write at the first free slot
    always_ff @(posedge i_clk) begin
        if (i_push && slot == 2'd0) begin
            r_q0 <= i_data;
        end else if (pop) begin
            r_q0 <= r_q1;
        end
        if (i_push && slot == 2'd1) begin
            r_q1 <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/multi_ratio_clock_divider_unit.sv @@
// Multi-ratio clock divider: input register, divider core, result queue.
// Path: an accepted beat is held in the input register, then written into the result queue that drives the output.
// Throughput: one beat per cycle while the result queue has room; the core state update is one pass through a
// divisibility table lookup and a 32-bit saturating count and compare.
// Reset: synchronous active-low; thresholds return to 5571, channel count to 64.
// Depends on mrcd_pkg, mrcd_core and mrcd_out_queue.
`default_nettype none

module multi_ratio_clock_divider_unit
    import mrcd_pkg::*;
#(
    parameter int MAX_CHANNELS = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic signed [SAMPLE_W-1:0]  i_clock_sample,
    input  wire logic signed [SAMPLE_W-1:0]  i_reset_sample,
    input  wire logic                        i_clock_connected,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [MAX_CHANNELS-1:0]          o_gate_mask,
    output logic signed [SAMPLE_W-1:0]       o_gated_sample
);

    localparam int RES_W = MAX_CHANNELS + SAMPLE_W;

    logic                    r_in_valid;
    t_tick                   r_tick;
    logic                    adv, room, push;
    logic [MAX_CHANNELS-1:0] core_mask;
    logic signed [SAMPLE_W-1:0] core_sample;
    logic [RES_W-1:0]        q_out;

    assign adv        = r_in_valid & room;
    assign o_in_ready = ~r_in_valid | adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_tick.clock_sample    <= i_clock_sample;
            r_tick.reset_sample    <= i_reset_sample;
            r_tick.clock_connected <= i_clock_connected;
        end
    end

    mrcd_core #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_tick         (r_tick),
        .i_advance      (adv),
        .o_push         (push),
        .o_gate_mask    (core_mask),
        .o_gated_sample (core_sample)
    );

    mrcd_out_queue #(
        .WIDTH(RES_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({core_mask, core_sample}),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (q_out)
    );

    assign o_gate_mask    = q_out[RES_W-1:SAMPLE_W];
    assign o_gated_sample = q_out[SAMPLE_W-1:0];

`ifndef SYNTHESIS
    // A held input beat that cannot advance stays in the input register
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> r_in_valid)
        else $error("input beat dropped while the queue was full");

    // A nonzero gated sample needs an open gate
    a_gated_needs_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_gated_sample != '0) |-> (o_gate_mask != '0))
        else $error("gated sample passed with all gates closed");

    // No result beat right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule

`default_nettype wire

@@ tb/multi_ratio_clock_divider_unit_tb.sv @@
// Self-checking testbench for multi_ratio_clock_divider_unit: drives sample beats,
// mirrors the divider state in a scoreboard class and checks every gate result beat.
// Depends on mrcd_pkg and the multi_ratio_clock_divider_unit RTL.
`timescale 1ns / 100ps

module multi_ratio_clock_divider_unit_tb;
    import mrcd_pkg::*;

    localparam int NUM_GATES   = 64;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_SETTLE = 8;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
    // index 3 is not decoded by the block
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic [NUM_GATES-1:0]       mask;
        logic signed [SAMPLE_W-1:0] sample;
    } t_gate_result;

    // Mirror of the divider plus the queue of gate results still to arrive
    class gate_scoreboard;
        logic signed [SAMPLE_W-1:0] clk_thr;
        logic signed [SAMPLE_W-1:0] rst_thr;
        logic [COUNT_W-1:0]         chan_cnt;
        logic                       clk_prev;
        logic                       rst_prev;
        logic                       armed;
        logic [TIMER_W-1:0]         gap_cnt;
        logic [TIMER_W-1:0]         interval;
        logic [TIMER_W-1:0]         since;
        logic [COUNT_W-1:0]         step;
        logic [NUM_GATES-1:0]       gates;
        t_gate_result               expected_gates[$];
        int                         errors;

        function new();
            clk_thr  = THRESHOLD_RESET;
            rst_thr  = THRESHOLD_RESET;
            chan_cnt = CHANNELS_RESET;
            rst_prev = 1'b0;
            errors   = 0;
            clear_divider();
        endfunction

        function void clear_divider();
            clk_prev = 1'b0;
            armed    = 1'b0;
            gap_cnt  = '0;
            interval = '0;
            since    = '0;
            step     = '0;
            gates    = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_CLOCK_THRESHOLD: clk_thr = data;
                REG_RESET_THRESHOLD: rst_thr = data;
                REG_CHANNEL_COUNT:   chan_cnt = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_gates.size();
        endfunction

        // Accepted input beat: for a connected tick, advance the mirror and queue the gate result
        function void note_tick(logic signed [SAMPLE_W-1:0] clk_s,
                                logic signed [SAMPLE_W-1:0] rst_s, logic conn);
            logic                 rst_lvl;
            logic                 clk_lvl;
            logic                 clk_edge;
            int                   used;
            int                   i;
            logic [NUM_GATES-1:0] used_mask;
            logic [NUM_GATES-1:0] fresh;
            t_gate_result         res;
            if (!conn) return;

            // reset edge clears the divider state, but not the reset detector or the config registers
            rst_lvl = (rst_s >= rst_thr);
            if (rst_lvl && !rst_prev) clear_divider();
            rst_prev = rst_lvl;

            if (gap_cnt != '1) gap_cnt = gap_cnt + 1'b1;
            clk_lvl  = (clk_s >= clk_thr);
            clk_edge = clk_lvl && !clk_prev;
            clk_prev = clk_lvl;
            if (clk_edge) begin
                interval = gap_cnt;
                gap_cnt  = '0;
            end

            used      = (chan_cnt < NUM_GATES) ? int'(chan_cnt) : NUM_GATES;
            used_mask = (used >= NUM_GATES) ? '1 : ((64'd1 << used) - 64'd1);

            if (!armed) begin
                if (clk_edge) armed = 1'b1;
            end else begin
                if (since != '1) since = since + 1'b1;
                if (clk_edge) begin
                    step  = step + 1'b1;
                    since = '0;
                    fresh = '0;
                    for (i = 0; i < used; i++) begin
                        if ((int'(step) % (i + 1)) == 0) fresh[i] = 1'b1;
                    end
                    gates = (gates & ~used_mask) | fresh;
                end else if (since >= (interval >> 1)) begin
                    gates = gates & ~used_mask;
                end
                if (step >= chan_cnt) step = '0;
            end

            res.mask   = gates;
            res.sample = (gates != '0) ? clk_s : '0;
            expected_gates.push_back(res);
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // Accepted result beat: compare with the oldest expectation
        task check_gates(logic [NUM_GATES-1:0] mask, logic signed [SAMPLE_W-1:0] sample);
            t_gate_result want;
            if (expected_gates.size() == 0) begin
                report($sformatf("result with nothing expected, mask %h", mask));
                return;
            end
            want = expected_gates.pop_front();
            if (mask !== want.mask)
                report($sformatf("gate_mask %h, expected %h", mask, want.mask));
            if (sample !== want.sample)
                report($sformatf("gated_sample %0d, expected %0d", sample, want.sample));
        endtask
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] i_clock_sample = '0;
    logic signed [SAMPLE_W-1:0] i_reset_sample = '0;
    logic                       i_clock_connected = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [NUM_GATES-1:0]       o_gate_mask;
    logic signed [SAMPLE_W-1:0] o_gated_sample;

    gate_scoreboard sb = new();
    bit             hold_request = 1'b0;
    int             cycle_count = 0;

    multi_ratio_clock_divider_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_clock_sample   (i_clock_sample),
        .i_reset_sample   (i_reset_sample),
        .i_clock_connected(i_clock_connected),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_gate_mask      (o_gate_mask),
        .o_gated_sample   (o_gated_sample)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: check accepted beats, then pick next ready
    initial begin : result_sink
        int stall_left;
        int free_left;
        int hold_left;
        int r;
        stall_left = 0;
        free_left  = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready)
                sb.check_gates(o_gate_mask, o_gated_sample);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            r = $urandom_range(0, 99);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (free_left > 0) begin
                free_left--;
                i_out_ready <= 1'b1;
            end else if (r < 10) begin
                stall_left = $urandom_range(0, 3);
                i_out_ready <= 1'b0;
            end else if (r < 12) begin
                stall_left = $urandom_range(10, 50);
                i_out_ready <= 1'b0;
            end else begin
                if (r < 15) free_left = $urandom_range(50, 200);
                i_out_ready <= 1'b1;
            end
        end
    end

    // One input beat; valid stays high on return so beats can go back to back
    task automatic send_tick(logic signed [SAMPLE_W-1:0] clk_s,
                             logic signed [SAMPLE_W-1:0] rst_s, logic conn, bit no_gaps);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)  gap = 0;
        else if (r < 85)        gap = $urandom_range(1, 3);
        else if (r < 97)        gap = $urandom_range(4, 10);
        else                    gap = $urandom_range(20, 60);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_clock_sample    <= clk_s;
        i_reset_sample    <= rst_s;
        i_clock_connected <= conn;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_tick(clk_s, rst_s, conn);
    endtask

    // Drop valid and wait until every queued result has come out
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    // Back-to-back register writes, enable lowered once at the end
    task automatic program_divider(logic signed [SAMPLE_W-1:0] clk_thr,
                                   logic signed [SAMPLE_W-1:0] rst_thr,
                                   logic [CFG_DATA_W-1:0] chans);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        int k;
        idx[0] = REG_CLOCK_THRESHOLD; val[0] = clk_thr;
        idx[1] = REG_RESET_THRESHOLD; val[1] = rst_thr;
        idx[2] = REG_CHANNEL_COUNT;   val[2] = chans;
        idx[3] = REG_SPARE;           val[3] = $urandom_range(0, 65535);
        for (k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            sb.write_reg(idx[k], val[k]);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random sample on the requested side of a threshold
    function automatic logic signed [SAMPLE_W-1:0] level_sample(
            logic signed [SAMPLE_W-1:0] thr, bit high);
        int lo;
        int hi;
        if (high) begin
            lo = thr;
            hi = 32767;
        end else begin
            if (thr == S_MIN) return $urandom;
            lo = -32768;
            hi = int'(thr) - 1;
        end
        if ($urandom_range(0, 3) == 0)
            return high ? lo + $urandom_range(0, (hi - lo) < 3 ? hi - lo : 3)
                        : hi - $urandom_range(0, (hi - lo) < 3 ? hi - lo : 3);
        return lo + $urandom_range(0, hi - lo);
    endfunction

    // Mostly square-wave clock bursts with sparse reset pulses, some noise beats;
    // sends exactly n beats, skipped ticks included
    task automatic random_ticks(int n);
        int sent;
        int period;
        int high_len;
        int k;
        bit no_gaps;
        logic conn;
        logic signed [SAMPLE_W-1:0] c;
        logic signed [SAMPLE_W-1:0] r;
        sent = 0;
        while (sent < n) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 8) begin
                period   = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 40)
                                                       : $urandom_range(2, 10);
                high_len = $urandom_range(1, period - 1);
                repeat ($urandom_range(1, 4)) begin
                    for (k = 0; k < period && sent < n; k++) begin
                        r    = level_sample(sb.rst_thr, $urandom_range(0, 29) == 0);
                        c    = level_sample(sb.clk_thr, k >= period - high_len);
                        conn = ($urandom_range(0, 19) != 0);
                        send_tick(c, r, conn, no_gaps);
                        sent++;
                    end
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    if (sent < n) begin
                        conn = $urandom_range(0, 1);
                        send_tick($urandom, $urandom, conn, no_gaps);
                        sent++;
                    end
                end
            end
        end
    endtask

    task automatic run_setting(logic signed [SAMPLE_W-1:0] clk_thr,
                               logic signed [SAMPLE_W-1:0] rst_thr,
                               logic [CFG_DATA_W-1:0] chans, int n, bit hold);
        wait_idle();
        program_divider(clk_thr, rst_thr, chans);
        if (hold) hold_request = 1'b1;
        random_ticks(n);
    endtask

    // Directed beats at reset settings: threshold boundaries, skipped ticks,
    // reset and clock edge in one tick, ends on a clock edge with gates open
    task automatic directed_ticks();
        send_tick(S_MAX, S_MAX, 1'b0, 1'b0);
        send_tick(S_MIN, S_MIN, 1'b1, 1'b0);
        send_tick(S_MAX, S_MIN, 1'b1, 1'b0);
        send_tick(S_MIN, S_MIN, 1'b1, 1'b0);
        send_tick(S_MIN, S_MIN, 1'b1, 1'b0);
        send_tick(16'sd5571, S_MIN, 1'b1, 1'b0);
        send_tick(16'sd5570, S_MIN, 1'b1, 1'b0);
        send_tick(16'sd5570, S_MIN, 1'b1, 1'b0);
        send_tick(S_MAX, 16'sd5570, 1'b1, 1'b0);
        send_tick(16'sd0, S_MIN, 1'b1, 1'b0);
        send_tick(S_MAX, S_MIN, 1'b0, 1'b0);
        send_tick(S_MIN, S_MIN, 1'b1, 1'b0);
        send_tick(S_MAX, 16'sd5571, 1'b1, 1'b0);
        send_tick(S_MIN, S_MAX, 1'b1, 1'b0);
        send_tick(S_MAX, S_MAX, 1'b1, 1'b0);
        send_tick(S_MIN, S_MIN, 1'b1, 1'b0);
        repeat (3) begin
            send_tick(S_MIN, S_MIN, 1'b1, 1'b1);
            send_tick(S_MIN, S_MIN, 1'b1, 1'b1);
            send_tick(S_MAX, S_MIN, 1'b1, 1'b1);
        end
    endtask

    // Main sequence
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_ticks();
        // count lowered while upper gates are open: they must stay put
        run_setting(THRESHOLD_RESET, THRESHOLD_RESET, 16'd2, 60, 1'b1);
        run_setting(S_MIN, S_MAX, 16'd64, 40, 1'b0);
        run_setting(S_MAX, S_MIN, 16'd0, 40, 1'b0);
        run_setting(16'sd0, 16'sd0, 16'd127, 90, 1'b1);
        run_setting($urandom, $urandom, 16'd100, 80, 1'b0);
        run_setting(16'sd0, 16'sd2000, 16'd1, 80, 1'b0);
        run_setting(-16'sd3000, 16'sd3000, 16'd65, 60, 1'b0);
        repeat (5) begin
            run_setting(level_sample(16'sd0, $urandom_range(0, 1)),
                        level_sample(16'sd0, $urandom_range(0, 1)),
                        $urandom_range(1, 64), 80, 1'b0);
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (sb.pending() > 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
